>>> rtl/core/mbtcp_pkg.sv
// Shared types and constants for the Modbus TCP frame responder.
package mbtcp_pkg;

  // Frame layout
  localparam int unsigned HDR_BYTES        = 12;
  localparam int unsigned PREFIX_BYTES     = 6;
  localparam int unsigned MULTI_WR_MIN_LEN = 13;

  // Quantity limits for read requests
  localparam logic [15:0] READ_BITS_MAX = 16'd2000;
  localparam logic [15:0] READ_REGS_MAX = 16'd125;

  // Function codes
  localparam logic [7:0] FC_READ_COILS      = 8'h01;
  localparam logic [7:0] FC_READ_DISC_IN    = 8'h02;
  localparam logic [7:0] FC_READ_HOLD_REGS  = 8'h03;
  localparam logic [7:0] FC_READ_INPUT_REGS = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL      = 8'h05;
  localparam logic [7:0] FC_WRITE_REG       = 8'h06;
  localparam logic [7:0] FC_WRITE_COILS     = 8'h0F;
  localparam logic [7:0] FC_WRITE_REGS      = 8'h10;

  // Exception handling
  localparam logic [7:0]  EXC_FLAG          = 8'h80;
  localparam logic [7:0]  EXC_ILLEGAL_FUNC  = 8'h01;
  localparam logic [7:0]  EXC_ILLEGAL_VALUE = 8'h03;
  localparam logic [15:0] EXC_RESP_LEN      = 16'd3;
  localparam logic [15:0] WRITE_RESP_LEN    = 16'd6;

  // Kind of response descriptor
  typedef enum logic [1:0] {
    KIND_NORMAL    = 2'd0,
    KIND_EXCEPTION = 2'd1,
    KIND_REJECT    = 2'd2
  } resp_kind_t;

  // One response descriptor
  typedef struct packed {
    logic [7:0]  zero_fill;
    logic        echo_valid;
    logic [15:0] echo_value;
    logic [15:0] echo_addr;
    logic [7:0]  count_or_code;
    logic [7:0]  func_out;
    logic [7:0]  unit_id;
    logic [15:0] resp_length;
    logic [15:0] proto_id;
    logic [15:0] txn_id;
  } resp_t;

endpackage

>>> rtl/core/modbus_tcp_frame_responder.sv
// Modbus TCP frame responder: framing, prefix checks and response descriptor.
// A descriptor reaches the output register in the cycle after the input transfer of a
// frame's last byte (or its sixth byte for a rejected prefix).
// Throughput: one byte per cycle; a byte is taken while the output register is
// empty or its descriptor is being taken in the same cycle.
// Reset (rst, synchronous) clears the byte counter, frame length, reject mode
// and the output valid; the header bytes are not reset.
module modbus_tcp_frame_responder #(
  parameter int unsigned MAX_FRAME_BYTES = 260
) (
  input  logic         clk,
  input  logic         rst,
  // Input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] rx_byte
  input  logic [0:0]   s_tuser,   // [0] stream_start
  // Response descriptors
  output logic         m_tvalid,
  input  logic         m_tready,
  // [15:0] txn_id, [31:16] proto_id, [47:32] resp_length, [55:48] unit_id,
  // [63:56] func_out, [71:64] count_or_code, [87:72] echo_addr,
  // [103:88] echo_value, [104] echo_valid, [112:105] zero_fill, [119:113] zero
  output logic [119:0] m_tdata,
  output logic [1:0]   m_tuser    // [1:0] resp_kind
);

  localparam int unsigned HDR = mbtcp_pkg::HDR_BYTES;

  // State
  logic [8:0] byte_index;
  logic [8:0] frame_length;
  logic       reject_mode;
  logic [7:0] header_store [HDR];

  // Output register
  mbtcp_pkg::resp_t      resp_reg;
  mbtcp_pkg::resp_kind_t kind_reg;

  // Datapath signals
  logic                  in_xfer;
  logic                  start;
  logic                  active;
  logic [8:0]            idx_cur;
  logic [8:0]            idx_next;
  logic [7:0]            hdr_view [HDR];
  logic [15:0]           proto_val;
  logic [15:0]           mb_len;
  logic                  prefix_done;
  logic                  prefix_bad;
  logic                  frame_end;
  logic                  produce;
  logic [7:0]            fn;
  logic [15:0]           qty;
  logic [7:0]            cnt;
  logic [16:0]           coil_sum;
  mbtcp_pkg::resp_t      resp_next;
  mbtcp_pkg::resp_kind_t kind_next;

  // Handshake: the output register frees up when its descriptor is taken.
  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  // Framing position for the incoming byte
  assign start    = s_tuser[0];
  assign active   = start || !reject_mode;
  assign idx_cur  = start ? 9'd0 : byte_index;
  assign idx_next = idx_cur + 9'd1;

  // Header as it stands once the incoming byte is written
  always_comb begin
    for (int i = 0; i < HDR; i++) begin
      hdr_view[i] = (idx_cur == 9'(i)) ? s_tdata : header_store[i];
    end
  end

  // Prefix checks on the sixth byte
  assign proto_val   = {hdr_view[2], hdr_view[3]};
  assign mb_len      = {hdr_view[4], hdr_view[5]};
  assign prefix_done = active && (idx_next == 9'(mbtcp_pkg::PREFIX_BYTES));
  assign prefix_bad  = (proto_val != 16'd0) || (mb_len < 16'd2) ||
                       ((17'(mb_len) + 17'(mbtcp_pkg::PREFIX_BYTES)) >
                        17'(MAX_FRAME_BYTES));
  assign frame_end   = active && (idx_next > 9'(mbtcp_pkg::PREFIX_BYTES)) &&
                       (idx_next >= frame_length);
  assign produce     = (prefix_done && prefix_bad) || frame_end;

  assign fn       = hdr_view[7];
  assign qty      = {hdr_view[10], hdr_view[11]};
  assign coil_sum = 17'(qty) + 17'd7;

  // Response descriptor
  always_comb begin
    resp_next          = '0;
    kind_next          = mbtcp_pkg::KIND_NORMAL;
    cnt                = '0;
    resp_next.txn_id   = {hdr_view[0], hdr_view[1]};
    resp_next.proto_id = proto_val;
    if (prefix_done) begin
      kind_next = mbtcp_pkg::KIND_REJECT;
    end else begin
      resp_next.unit_id = hdr_view[6];
      case (fn)
        mbtcp_pkg::FC_READ_COILS, mbtcp_pkg::FC_READ_DISC_IN,
        mbtcp_pkg::FC_READ_HOLD_REGS, mbtcp_pkg::FC_READ_INPUT_REGS: begin
          if (fn == mbtcp_pkg::FC_READ_COILS || fn == mbtcp_pkg::FC_READ_DISC_IN) begin
            cnt = 8'(coil_sum >> 3);
          end else begin
            cnt = 8'({qty, 1'b0});
          end
          if (frame_length < 9'(HDR) || qty == 16'd0 ||
              ((fn == mbtcp_pkg::FC_READ_COILS || fn == mbtcp_pkg::FC_READ_DISC_IN) &&
               qty > mbtcp_pkg::READ_BITS_MAX) ||
              ((fn == mbtcp_pkg::FC_READ_HOLD_REGS || fn == mbtcp_pkg::FC_READ_INPUT_REGS) &&
               qty > mbtcp_pkg::READ_REGS_MAX)) begin
            kind_next               = mbtcp_pkg::KIND_EXCEPTION;
            resp_next.resp_length   = mbtcp_pkg::EXC_RESP_LEN;
            resp_next.func_out      = fn | mbtcp_pkg::EXC_FLAG;
            resp_next.count_or_code = mbtcp_pkg::EXC_ILLEGAL_VALUE;
          end else begin
            resp_next.resp_length   = 16'd3 + 16'(cnt);
            resp_next.func_out      = fn;
            resp_next.count_or_code = cnt;
            resp_next.zero_fill     = cnt;
          end
        end
        mbtcp_pkg::FC_WRITE_COIL, mbtcp_pkg::FC_WRITE_REG,
        mbtcp_pkg::FC_WRITE_COILS, mbtcp_pkg::FC_WRITE_REGS: begin
          if ((frame_length < 9'(HDR)) ||
              ((fn == mbtcp_pkg::FC_WRITE_COILS || fn == mbtcp_pkg::FC_WRITE_REGS) &&
               frame_length < 9'(mbtcp_pkg::MULTI_WR_MIN_LEN))) begin
            kind_next               = mbtcp_pkg::KIND_EXCEPTION;
            resp_next.resp_length   = mbtcp_pkg::EXC_RESP_LEN;
            resp_next.func_out      = fn | mbtcp_pkg::EXC_FLAG;
            resp_next.count_or_code = mbtcp_pkg::EXC_ILLEGAL_VALUE;
          end else begin
            resp_next.resp_length = mbtcp_pkg::WRITE_RESP_LEN;
            resp_next.func_out    = fn;
            resp_next.echo_addr   = {hdr_view[8], hdr_view[9]};
            resp_next.echo_value  = qty;
            resp_next.echo_valid  = 1'b1;
          end
        end
        default: begin
          kind_next               = mbtcp_pkg::KIND_EXCEPTION;
          resp_next.resp_length   = mbtcp_pkg::EXC_RESP_LEN;
          resp_next.func_out      = fn | mbtcp_pkg::EXC_FLAG;
          resp_next.count_or_code = mbtcp_pkg::EXC_ILLEGAL_FUNC;
        end
      endcase
    end
  end

  // Framer state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= '0;
      frame_length <= '0;
      reject_mode  <= 1'b0;
    end else if (in_xfer && active) begin
      byte_index  <= frame_end ? 9'd0 : idx_next;
      reject_mode <= 1'b0;
      if (prefix_done) begin
        if (prefix_bad) begin
          reject_mode <= 1'b1;
        end else begin
          frame_length <= 9'(17'(mb_len) + 17'(mbtcp_pkg::PREFIX_BYTES));
        end
      end
    end
  end

  // Header bytes of the current frame
  always_ff @(posedge clk) begin
    if (in_xfer && active && idx_cur < 9'(HDR)) begin
      header_store[4'(idx_cur)] <= s_tdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= produce;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && produce) begin
      resp_reg <= resp_next;
      kind_reg <= kind_next;
    end
  end

  assign m_tdata = {7'd0, resp_reg};
  assign m_tuser = kind_reg;

  // A rejected prefix always leaves the framer in reject mode.
  a_reject_mode : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && kind_reg == mbtcp_pkg::KIND_REJECT) |-> reject_mode)
    else $error("reject descriptor without reject mode");

  // The counter restarts once it reaches the frame length.
  a_index_bound : assert property (@(posedge clk) disable iff (rst)
    (byte_index > 9'(mbtcp_pkg::PREFIX_BYTES)) |-> (byte_index < frame_length))
    else $error("byte counter ran past frame end");

  // Exceptions carry the flag bit and the fixed length.
  a_exc_shape : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && kind_reg == mbtcp_pkg::KIND_EXCEPTION) |->
      (resp_reg.func_out[7] && resp_reg.resp_length == mbtcp_pkg::EXC_RESP_LEN &&
       !resp_reg.echo_valid))
    else $error("malformed exception descriptor");

  // Read responses fill exactly the byte count with zeros.
  a_read_fill : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && kind_reg == mbtcp_pkg::KIND_NORMAL && !resp_reg.echo_valid) |->
      (resp_reg.zero_fill == resp_reg.count_or_code &&
       resp_reg.resp_length == 16'd3 + 16'(resp_reg.count_or_code)))
    else $error("read descriptor fill mismatch");

endmodule

>>> test/tb_modbus_tcp_frame_responder.sv
// Testbench for the Modbus TCP frame responder: request byte streams checked against a predictor.
`timescale 1ns / 100ps

module tb_modbus_tcp_frame_responder;

  localparam int FRAME_LIMIT = 260;
  localparam int CYCLE_LIMIT = 200_000;

  // One expected descriptor as it should leave the block.
  typedef struct {
    mbtcp_pkg::resp_kind_t kind;
    mbtcp_pkg::resp_t      r;
  } descriptor_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;   // [7:0] rx_byte
  logic [0:0]   s_tuser = '0;   // [0] stream_start
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // [15:0] txn_id, [31:16] proto_id, [47:32] resp_length, [55:48] unit_id,
  // [63:56] func_out, [71:64] count_or_code, [87:72] echo_addr,
  // [103:88] echo_value, [104] echo_valid, [112:105] zero_fill, [119:113] zero
  logic [119:0] m_tdata;
  logic [1:0]   m_tuser;        // [1:0] resp_kind

  // Framing state of the predictor.
  logic [8:0]  frame_pos = '0;
  logic [7:0]  header_bytes [mbtcp_pkg::HDR_BYTES];
  logic [8:0]  frame_bytes = '0;
  bit          rejecting = 1'b0;

  descriptor_t responses_due [$];
  int          mismatches = 0;
  int          live_bytes = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          take_idle_pct = 0;

  logic [7:0] known_fc [8] = '{mbtcp_pkg::FC_READ_COILS, mbtcp_pkg::FC_READ_DISC_IN,
                               mbtcp_pkg::FC_READ_HOLD_REGS, mbtcp_pkg::FC_READ_INPUT_REGS,
                               mbtcp_pkg::FC_WRITE_COIL, mbtcp_pkg::FC_WRITE_REG,
                               mbtcp_pkg::FC_WRITE_COILS, mbtcp_pkg::FC_WRITE_REGS};

  modbus_tcp_frame_responder #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Run guard: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Builds the descriptor for a complete frame from the stored header.
  function automatic descriptor_t answer_for_frame();
    descriptor_t d;
    logic [7:0]  fc;
    logic [15:0] qty;
    logic [15:0] cnt;
    logic [7:0]  code;
    bit          bad;
    d.kind = mbtcp_pkg::KIND_NORMAL;
    d.r = '0;
    fc = header_bytes[7];
    bad = 1'b0;
    code = mbtcp_pkg::EXC_ILLEGAL_VALUE;
    d.r.txn_id = {header_bytes[0], header_bytes[1]};
    d.r.proto_id = {header_bytes[2], header_bytes[3]};
    d.r.unit_id = header_bytes[6];
    case (fc)
      mbtcp_pkg::FC_READ_COILS, mbtcp_pkg::FC_READ_DISC_IN,
      mbtcp_pkg::FC_READ_HOLD_REGS, mbtcp_pkg::FC_READ_INPUT_REGS: begin
        if (frame_bytes < mbtcp_pkg::HDR_BYTES) begin
          bad = 1'b1;
        end else begin
          qty = {header_bytes[10], header_bytes[11]};
          if (fc <= mbtcp_pkg::FC_READ_DISC_IN) begin
            bad = (qty < 16'd1) || (qty > mbtcp_pkg::READ_BITS_MAX);
            cnt = (qty + 16'd7) >> 3;
          end else begin
            bad = (qty < 16'd1) || (qty > mbtcp_pkg::READ_REGS_MAX);
            cnt = qty << 1;
          end
          if (!bad) begin
            d.r.resp_length = 16'd3 + cnt;
            d.r.func_out = fc;
            d.r.count_or_code = cnt[7:0];
            d.r.zero_fill = cnt[7:0];
          end
        end
      end
      mbtcp_pkg::FC_WRITE_COIL, mbtcp_pkg::FC_WRITE_REG,
      mbtcp_pkg::FC_WRITE_COILS, mbtcp_pkg::FC_WRITE_REGS: begin
        bad = frame_bytes < ((fc <= mbtcp_pkg::FC_WRITE_REG) ? mbtcp_pkg::HDR_BYTES :
                             mbtcp_pkg::MULTI_WR_MIN_LEN);
        if (!bad) begin
          d.r.resp_length = mbtcp_pkg::WRITE_RESP_LEN;
          d.r.func_out = fc;
          d.r.echo_addr = {header_bytes[8], header_bytes[9]};
          d.r.echo_value = {header_bytes[10], header_bytes[11]};
          d.r.echo_valid = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
        code = mbtcp_pkg::EXC_ILLEGAL_FUNC;
      end
    endcase
    if (bad) begin
      d.kind = mbtcp_pkg::KIND_EXCEPTION;
      d.r.resp_length = mbtcp_pkg::EXC_RESP_LEN;
      d.r.func_out = fc | mbtcp_pkg::EXC_FLAG;
      d.r.count_or_code = code;
    end
    return d;
  endfunction

  // Advances the predictor by one accepted byte; taken is low for a dropped byte.
  task automatic track_byte(input logic [7:0] b, input logic st, output bit taken);
    descriptor_t d;
    int          body_len;
    taken = 1'b0;
    if (st) begin
      frame_pos = '0;
      rejecting = 1'b0;
    end
    if (rejecting) return;
    taken = 1'b1;
    if (frame_pos < mbtcp_pkg::HDR_BYTES) header_bytes[4'(frame_pos)] = b;
    frame_pos = frame_pos + 9'd1;
    if (frame_pos == mbtcp_pkg::PREFIX_BYTES) begin
      body_len = int'({header_bytes[4], header_bytes[5]});
      if ({header_bytes[2], header_bytes[3]} != 16'd0 || body_len < 2 ||
          body_len + 6 > FRAME_LIMIT) begin
        rejecting = 1'b1;
        d.kind = mbtcp_pkg::KIND_REJECT;
        d.r = '0;
        d.r.txn_id = {header_bytes[0], header_bytes[1]};
        d.r.proto_id = {header_bytes[2], header_bytes[3]};
        responses_due.insert(responses_due.size(), d);
      end else begin
        frame_bytes = 9'(body_len + 6);
      end
    end else if (frame_pos > mbtcp_pkg::PREFIX_BYTES && frame_pos >= frame_bytes) begin
      responses_due.insert(responses_due.size(), answer_for_frame());
      frame_pos = '0;
    end
  endtask

  // Sends one byte, with a random gap first, and waits for its transfer.
  task automatic send_byte(input logic [7:0] b, input logic st);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= st;
    do @(posedge clk); while (!s_tready);
    track_byte(b, st, taken);
    if (taken) live_bytes++;
  endtask

  // Sends nbytes of a request frame; bytes past the header are random.
  task automatic send_frame(input logic [15:0] txn, input logic [15:0] proto,
                            input logic [15:0] mlen, input logic [7:0] unit,
                            input logic [7:0] fc, input logic [15:0] addr,
                            input logic [15:0] qty, input int nbytes, input logic st);
    logic [7:0] b;
    for (int i = 0; i < nbytes; i++) begin
      case (i)
        0:       b = txn[15:8];
        1:       b = txn[7:0];
        2:       b = proto[15:8];
        3:       b = proto[7:0];
        4:       b = mlen[15:8];
        5:       b = mlen[7:0];
        6:       b = unit;
        7:       b = fc;
        8:       b = addr[15:8];
        9:       b = addr[7:0];
        10:      b = qty[15:8];
        11:      b = qty[7:0];
        default: b = 8'($urandom);
      endcase
      send_byte(b, (i == 0) ? st : 1'b0);
    end
  endtask

  // Holds the input until every expected descriptor has been taken.
  task automatic drain_responses();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (responses_due.size() != 0);
  endtask

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want)
      note_failure($sformatf("%s expected 0x%04h, got 0x%04h", name, want, got));
  endfunction

  // Random output stall and descriptor checking.
  always @(posedge clk) begin
    descriptor_t      want;
    mbtcp_pkg::resp_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = mbtcp_pkg::resp_t'(m_tdata[112:0]);
      if (responses_due.size() == 0) begin
        note_failure($sformatf("descriptor with none expected, kind %0d txn 0x%04h",
                               m_tuser, got.txn_id));
      end else begin
        want = responses_due.pop_front();
        compare_field("resp_kind", 16'(want.kind), 16'(m_tuser));
        compare_field("txn_id", want.r.txn_id, got.txn_id);
        compare_field("proto_id", want.r.proto_id, got.proto_id);
        compare_field("resp_length", want.r.resp_length, got.resp_length);
        compare_field("unit_id", 16'(want.r.unit_id), 16'(got.unit_id));
        compare_field("func_out", 16'(want.r.func_out), 16'(got.func_out));
        compare_field("count_or_code", 16'(want.r.count_or_code), 16'(got.count_or_code));
        compare_field("echo_addr", want.r.echo_addr, got.echo_addr);
        compare_field("echo_value", want.r.echo_value, got.echo_value);
        compare_field("echo_valid", 16'(want.r.echo_valid), 16'(got.echo_valid));
        compare_field("zero_fill", 16'(want.r.zero_fill), 16'(got.zero_fill));
        compare_field("padding", 16'd0, 16'(m_tdata[119:113]));
      end
    end
    m_tready <= ($urandom_range(99) >= take_idle_pct);
  end

  // Reads at both ends of their quantity ranges, one frame with trailing bytes.
  task automatic test_read_responses();
    send_frame(16'hFFFF, 16'h0000, 16'd6, 8'hFF, mbtcp_pkg::FC_READ_COILS, 16'h0000, 16'd1,
               12, 1'b1);
    send_frame(16'h0000, 16'h0000, 16'd6, 8'h00, mbtcp_pkg::FC_READ_DISC_IN, 16'hFFFF,
               mbtcp_pkg::READ_BITS_MAX, 12, 1'b1);
    send_frame(16'h1234, 16'h0000, 16'd6, 8'h11, mbtcp_pkg::FC_READ_HOLD_REGS, 16'h0010,
               mbtcp_pkg::READ_REGS_MAX, 12, 1'b0);
    send_frame(16'h5AA5, 16'h0000, 16'd9, 8'h01, mbtcp_pkg::FC_READ_INPUT_REGS, 16'h8000,
               16'd1, 15, 1'b0);
  endtask

  // Write echoes, including the shortest legal multiple write.
  task automatic test_write_echoes();
    send_frame(16'h0101, 16'h0000, 16'd6, 8'h7F, mbtcp_pkg::FC_WRITE_COIL, 16'hFFFF, 16'hFF00,
               12, 1'b1);
    send_frame(16'h0202, 16'h0000, 16'd6, 8'h80, mbtcp_pkg::FC_WRITE_REG, 16'h00A5, 16'h0000,
               12, 1'b0);
    send_frame(16'h0303, 16'h0000, 16'd8, 8'h02, mbtcp_pkg::FC_WRITE_COILS, 16'h0013, 16'd10,
               14, 1'b0);
    send_frame(16'h0404, 16'h0000, 16'd7, 8'h03, mbtcp_pkg::FC_WRITE_REGS, 16'h4000, 16'd1,
               13, 1'b0);
  endtask

  // Quantities out of range, short frames and unknown function codes.
  task automatic test_exceptions();
    send_frame(16'h1001, 16'h0000, 16'd6, 8'h01, mbtcp_pkg::FC_READ_COILS, 16'h0000, 16'd0,
               12, 1'b1);
    send_frame(16'h1002, 16'h0000, 16'd6, 8'h01, mbtcp_pkg::FC_READ_DISC_IN, 16'h0000,
               mbtcp_pkg::READ_BITS_MAX + 16'd1, 12, 1'b0);
    send_frame(16'h1003, 16'h0000, 16'd6, 8'h01, mbtcp_pkg::FC_READ_HOLD_REGS, 16'h0000,
               mbtcp_pkg::READ_REGS_MAX + 16'd1, 12, 1'b0);
    send_frame(16'h1004, 16'h0000, 16'd6, 8'h01, mbtcp_pkg::FC_READ_INPUT_REGS, 16'h0000,
               16'hFFFF, 12, 1'b0);
    send_frame(16'h1005, 16'h0000, 16'd5, 8'h01, mbtcp_pkg::FC_READ_HOLD_REGS, 16'h0000,
               16'd1, 11, 1'b0);
    send_frame(16'h1006, 16'h0000, 16'd2, 8'h01, mbtcp_pkg::FC_WRITE_COIL, 16'h0000, 16'd0,
               8, 1'b0);
    send_frame(16'h1007, 16'h0000, 16'd6, 8'h01, mbtcp_pkg::FC_WRITE_COILS, 16'h0000, 16'd8,
               12, 1'b0);
    send_frame(16'h1008, 16'h0000, 16'd2, 8'h01, 8'h00, 16'h0000, 16'd0, 8, 1'b0);
    send_frame(16'h1009, 16'h0000, 16'd6, 8'h01, 8'hFF, 16'h0000, 16'd0, 12, 1'b0);
    send_frame(16'h100A, 16'h0000, 16'd6, 8'h01, 8'h07, 16'h0000, 16'd0, 12, 1'b0);
  endtask

  // Bad prefixes are rejected and the rest of the stream is dropped until a restart.
  task automatic test_prefix_rejects();
    send_frame(16'hABCD, 16'hFFFF, 16'd6, 8'h01, mbtcp_pkg::FC_READ_COILS, 16'h0000, 16'd1,
               12, 1'b1);
    send_frame(16'h0001, 16'h0000, 16'd6, 8'h01, mbtcp_pkg::FC_READ_COILS, 16'h0000, 16'd1,
               12, 1'b0);
    send_frame(16'h0002, 16'h0000, 16'd0, 8'h01, mbtcp_pkg::FC_READ_COILS, 16'h0000, 16'd1,
               8, 1'b1);
    send_frame(16'h0003, 16'h0000, 16'd1, 8'h01, mbtcp_pkg::FC_READ_COILS, 16'h0000, 16'd1,
               8, 1'b1);
    send_frame(16'h0004, 16'h0000, 16'd255, 8'h01, mbtcp_pkg::FC_READ_COILS, 16'h0000, 16'd1,
               12, 1'b1);
    send_frame(16'h0005, 16'h0000, 16'hFFFF, 8'h01, mbtcp_pkg::FC_READ_COILS, 16'h0000, 16'd1,
               9, 1'b1);
    // The largest legal frame, almost all of it past the stored header.
    send_frame(16'h0006, 16'h0000, 16'd254, 8'h09, mbtcp_pkg::FC_READ_HOLD_REGS, 16'h0000,
               16'd2, 260, 1'b1);
  endtask

  // A stream start in the middle of a frame discards the partial frame.
  task automatic test_stream_restart();
    send_frame(16'h2001, 16'h0000, 16'd6, 8'h01, mbtcp_pkg::FC_READ_COILS, 16'h0000, 16'd9,
               9, 1'b1);
    send_frame(16'h2002, 16'h0000, 16'd6, 8'h02, mbtcp_pkg::FC_WRITE_REG, 16'h0001, 16'h1234,
               3, 1'b1);
    send_frame(16'h2003, 16'h0000, 16'd6, 8'h03, mbtcp_pkg::FC_WRITE_REG, 16'h0002, 16'h5678,
               12, 1'b1);
  endtask

  // Mostly well-formed requests with random content, plus broken frames and noise.
  task automatic test_random_stream(input int n);
    int          stop_at;
    int          r;
    int          nbytes;
    logic [7:0]  fc;
    logic [15:0] qty;
    logic [15:0] lim;
    logic [15:0] mlen;
    logic [15:0] proto;
    bit          restart;
    stop_at = live_bytes + n;
    restart = 1'b1;
    while (live_bytes < stop_at) begin
      r = $urandom_range(99);
      proto = 16'd0;
      fc = known_fc[$urandom_range(7)];
      lim = (fc <= mbtcp_pkg::FC_READ_DISC_IN) ? mbtcp_pkg::READ_BITS_MAX :
                                                  mbtcp_pkg::READ_REGS_MAX;
      case ($urandom_range(3))
        0:       qty = ($urandom_range(1) != 0) ? 16'($urandom_range(1)) :
                       lim + 16'($urandom_range(1));
        3:       qty = 16'($urandom);
        default: qty = 16'($urandom_range(lim, 1));
      endcase
      if (fc == mbtcp_pkg::FC_WRITE_COILS || fc == mbtcp_pkg::FC_WRITE_REGS)
        mlen = 16'($urandom_range(15, 7));
      else
        mlen = ($urandom_range(9) == 0) ? 16'($urandom_range(14, 7)) : 16'd6;
      if (r < 10) mlen = 16'($urandom_range(6, 2));
      else if (r < 20) fc = 8'($urandom);
      else if (r < 22) mlen = 16'($urandom_range(254, 13));
      nbytes = 6 + int'(mlen);
      if (r >= 22 && r < 30) begin
        // Bad prefix: a nonzero protocol id, a tiny length or an oversized frame.
        case ($urandom_range(2))
          0:       proto = 16'($urandom_range(65535, 1));
          1:       mlen = 16'($urandom_range(1));
          default: mlen = 16'($urandom_range(65535, FRAME_LIMIT - 5));
        endcase
        nbytes = 6 + $urandom_range(6);
      end else if (r >= 30 && r < 37) begin
        nbytes = $urandom_range(nbytes - 1, 1);
      end
      if (r >= 37 && r < 41) begin
        // Line noise with occasional stream starts.
        repeat ($urandom_range(12, 1)) send_byte(8'($urandom), $urandom_range(7) == 0);
        restart = 1'b1;
      end else begin
        send_frame(16'($urandom), proto, mlen, 8'($urandom), fc, 16'($urandom), qty, nbytes,
                   restart || rejecting || $urandom_range(3) == 0);
        restart = (r >= 30 && r < 37) ? ($urandom_range(1) != 0) : 1'b0;
      end
    end
  endtask

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 23;
    take_idle_pct = 85;
    test_read_responses();
    test_write_echoes();
    test_exceptions();
    test_prefix_rejects();
    test_stream_restart();
    test_random_stream(200);
    drain_responses();

    send_idle_pct = 85;
    take_idle_pct = 23;
    test_random_stream(200);
    drain_responses();

    send_idle_pct = 0;
    take_idle_pct = 0;
    test_random_stream(150);
    drain_responses();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && responses_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
